[src/vec3g_pkg.sv]
// Shared types, op codes and saturation helpers for the vec3 geometry unit.
// No dependencies; the lane, square-root, divider and top-level files import this package.
`timescale 1ns / 1ps
package vec3g_pkg;

   typedef logic signed [31:0] q_type;
   typedef logic signed [63:0] prod_type;
   typedef logic signed [65:0] wide_type;

   localparam logic [2:0] OP_DOT       = 3'd0;
   localparam logic [2:0] OP_CROSS     = 3'd1;
   localparam logic [2:0] OP_LENGTH    = 3'd2;
   localparam logic [2:0] OP_NORMALIZE = 3'd3;
   localparam logic [2:0] OP_REFLECT   = 3'd4;
   localparam logic [2:0] OP_REFRACT   = 3'd5;

   localparam q_type Q_MAX = 32'sh7FFFFFFF;
   localparam q_type Q_MIN = 32'sh80000000;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic signed [31:0] eta;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_x;
      logic signed [31:0] res_y;
      logic signed [31:0] res_z;
      logic signed [31:0] res_scalar;
      logic               total_reflection;
      logic               div_by_zero;
      logic               saturated;
   } rsp_type;

   // Per-request context carried down the long part of the pipeline.
   typedef struct packed {
      logic [2:0]        op;
      logic [2:0][31:0]  a;
      logic [2:0][31:0]  b;
      logic [31:0]       eta;
      logic [2:0][63:0]  fea;
      logic [2:0][63:0]  cb;
      logic [63:0]       fed;
      logic [31:0]       c;
      logic [2:0][31:0]  r;
      logic [31:0]       scalar;
      logic              tir;
      logic              dz;
      logic              sat;
   } ctx_type;

   function automatic wide_type sx32(input logic [31:0] v);
      return wide_type'($signed(v));
   endfunction

   function automatic wide_type sx64(input logic [63:0] v);
      return wide_type'($signed(v));
   endfunction

   function automatic prod_type mul32(input logic [31:0] x, input logic [31:0] y);
      return prod_type'($signed(x)) * prod_type'($signed(y));
   endfunction

   function automatic q_type clamp_q(input wide_type v);
      if (v > sx32(Q_MAX)) return Q_MAX;
      if (v < sx32(Q_MIN)) return Q_MIN;
      return q_type'(v);
   endfunction

   function automatic logic clamp_hit(input wide_type v);
      return (v > sx32(Q_MAX)) || (v < sx32(Q_MIN));
   endfunction

endpackage

[src/vec3g_stream_if.sv]
// Valid/ready stream interface used for the request and result channels.
// Payload type is supplied by the instantiating context.
`timescale 1ns / 1ps
interface vec3g_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[src/vec3g_lane.sv]
// One component lane: the products of a request and their scaled forms.
// Depends on vec3g_pkg.
`timescale 1ns / 1ps
module vec3g_lane import vec3g_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        en,
   input  q_type       a_i,
   input  q_type       a_j,
   input  q_type       a_k,
   input  q_type       b_i,
   input  q_type       b_j,
   input  q_type       b_k,
   input  q_type       eta,
   output prod_type    fab,
   output prod_type    fea,
   output logic [63:0] sq,
   output q_type       cross_q,
   output logic        cross_sat
);

   prod_type    ab_ff, ea_ff, sq_ff, cp_ff, cq_ff;
   prod_type    ab_in, ea_in, sq_in, cp_in, cq_in;
   prod_type    fab_ff, fea_ff, fab_in, fea_in;
   logic [63:0] sqs_ff, sqs_in;
   q_type       cross_ff, cross_in;
   logic        cross_sat_ff, cross_sat_in;
   wide_type    diff;

   always_comb begin
      ab_in = mul32(a_i, b_i);
      ea_in = mul32(eta, a_i);
      sq_in = mul32(a_i, a_i);
      cp_in = mul32(a_j, b_k);
      cq_in = mul32(a_k, b_j);
   end

   // Arithmetic right shift gives the floor of the scaled product.
   always_comb begin
      fab_in       = ab_ff >>> FRAC_BITS;
      fea_in       = ea_ff >>> FRAC_BITS;
      sqs_in       = $unsigned(sq_ff);
      diff         = sx64(cp_ff >>> FRAC_BITS) - sx64(cq_ff >>> FRAC_BITS);
      cross_in     = clamp_q(diff);
      cross_sat_in = clamp_hit(diff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ab_ff        <= ab_in;
         ea_ff        <= ea_in;
         sq_ff        <= sq_in;
         cp_ff        <= cp_in;
         cq_ff        <= cq_in;
         fab_ff       <= fab_in;
         fea_ff       <= fea_in;
         sqs_ff       <= sqs_in;
         cross_ff     <= cross_in;
         cross_sat_ff <= cross_sat_in;
      end
   end

   assign fab       = fab_ff;
   assign fea       = fea_ff;
   assign sq        = sqs_ff;
   assign cross_q   = cross_ff;
   assign cross_sat = cross_sat_ff;

endmodule

[src/vec3g_isqrt.sv]
// Pipelined integer floor square root of a 64-bit value, one result bit per stage.
// Depends on vec3g_pkg; carries a side record alongside each request.
`timescale 1ns / 1ps
module vec3g_isqrt import vec3g_pkg::*; #(
   parameter type side_type = logic
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [63:0] radicand,
   input  side_type    side_in,
   output logic        out_valid,
   output logic [31:0] root,
   output side_type    side_out
);

   localparam int STAGES = 32;

   logic [63:0] rem_ff  [STAGES];
   logic [63:0] r_ff    [STAGES];
   side_type    side_ff [STAGES];
   logic        valid_ff[STAGES];

   for (genvar t = 0; t < STAGES; t++) begin : g_stage
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * t);
      logic [63:0] rem_cur, r_cur, rem_in, r_in;
      side_type    side_cur;
      logic        valid_cur;

      if (t == 0) begin : g_first
         assign rem_cur   = radicand;
         assign r_cur     = '0;
         assign side_cur  = side_in;
         assign valid_cur = in_valid;
      end else begin : g_next
         assign rem_cur   = rem_ff[t-1];
         assign r_cur     = r_ff[t-1];
         assign side_cur  = side_ff[t-1];
         assign valid_cur = valid_ff[t-1];
      end

      always_comb begin
         if (rem_cur >= r_cur + BIT) begin
            rem_in = rem_cur - (r_cur + BIT);
            r_in   = (r_cur >> 1) + BIT;
         end else begin
            rem_in = rem_cur;
            r_in   = r_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[t] <= 1'b0;
         end else if (en) begin
            valid_ff[t] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[t]  <= rem_in;
            r_ff[t]    <= r_in;
            side_ff[t] <= side_cur;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign root      = r_ff[STAGES-1][31:0];
   assign side_out  = side_ff[STAGES-1];

endmodule

[src/vec3g_div.sv]
// Three-lane pipelined restoring divider for normalize, one quotient bit per stage.
// Depends on vec3g_pkg; carries a side record alongside each request.
`timescale 1ns / 1ps
module vec3g_div import vec3g_pkg::*; #(
   parameter int  FRAC_BITS = 16,
   parameter type side_type = logic
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [63:0] num [3],
   input  logic [31:0] den,
   input  side_type    side_in,
   output logic        out_valid,
   output logic [31:0] quot [3],
   output side_type    side_out
);

   localparam int QB = FRAC_BITS + 1;

   logic [63:0] rem_ff  [QB][3];
   logic [31:0] q_ff    [QB][3];
   logic [31:0] den_ff  [QB];
   side_type    side_ff [QB];
   logic        valid_ff[QB];

   for (genvar t = 0; t < QB; t++) begin : g_stage
      localparam int SH = QB - 1 - t;
      logic [63:0] rem_cur[3];
      logic [31:0] q_cur  [3];
      logic [63:0] rem_in [3];
      logic [31:0] q_in   [3];
      logic [31:0] den_cur;
      side_type    side_cur;
      logic        valid_cur;

      if (t == 0) begin : g_first
         assign rem_cur   = num;
         assign q_cur     = '{default: '0};
         assign den_cur   = den;
         assign side_cur  = side_in;
         assign valid_cur = in_valid;
      end else begin : g_next
         assign rem_cur   = rem_ff[t-1];
         assign q_cur     = q_ff[t-1];
         assign den_cur   = den_ff[t-1];
         assign side_cur  = side_ff[t-1];
         assign valid_cur = valid_ff[t-1];
      end

      always_comb begin
         logic [63:0] sub;
         sub = {32'd0, den_cur} << SH;
         for (int l = 0; l < 3; l++) begin
            if (rem_cur[l] >= sub) begin
               rem_in[l] = rem_cur[l] - sub;
               q_in[l]   = q_cur[l] | (32'd1 << SH);
            end else begin
               rem_in[l] = rem_cur[l];
               q_in[l]   = q_cur[l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[t] <= 1'b0;
         end else if (en) begin
            valid_ff[t] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[t]  <= rem_in;
            q_ff[t]    <= q_in;
            den_ff[t]  <= den_cur;
            side_ff[t] <= side_cur;
         end
      end
   end

   assign out_valid = valid_ff[QB-1];
   assign quot      = q_ff[QB-1];
   assign side_out  = side_ff[QB-1];

endmodule

[src/vec3_geometry_unit.sv]
// Vec3 geometry unit: dot, cross, length, normalize, reflect and refract in fixed point.
// Depends on vec3g_pkg, vec3g_stream_if, vec3g_lane, vec3g_isqrt and vec3g_div.
//
// Usage: a request on req carries op, vectors a and b and eta; each request gives
// exactly one result on rsp, in request order. Both channels are valid/ready and a
// transfer happens on a clock edge with valid and ready both high.
// The block is a single pipeline: three component lanes form the products, a
// merging stage sums the dot product, a shared 32-stage square-root pipeline serves
// length, normalize and refract, and a three-lane divider of FRAC_BITS+1 stages
// finishes normalize. Throughput is one request per cycle for every op while the
// output register is taken or empty.
// The result sits in an output register. While it is not taken, the whole pipeline
// holds and req.ready is low; as soon as it is taken, or the register is empty,
// the pipeline moves and a new request is taken in the same cycle.
// Reset (synchronous, active high) empties the pipeline; no data is held over.
`timescale 1ns / 1ps
module vec3_geometry_unit import vec3g_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input logic            clock,
   input logic            reset,
   vec3g_stream_if.sink   req,
   vec3g_stream_if.source rsp
);

   localparam wide_type ONE = wide_type'(1) << FRAC_BITS;

   logic    en;
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   assign en          = !rsp_valid_ff || rsp.ready;
   assign req.ready   = en;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   // Lanes
   q_type       av[3], bv[3];
   prod_type    fab_l[3], fea_l[3];
   logic [63:0] sq_l[3];
   q_type       cross_l[3];
   logic        cross_sat_l[3];

   assign av[0] = req.payload.a_x;
   assign av[1] = req.payload.a_y;
   assign av[2] = req.payload.a_z;
   assign bv[0] = req.payload.b_x;
   assign bv[1] = req.payload.b_y;
   assign bv[2] = req.payload.b_z;

   for (genvar i = 0; i < 3; i++) begin : g_lane
      vec3g_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock     (clock),
         .en        (en),
         .a_i       (av[i]),
         .a_j       (av[(i + 1) % 3]),
         .a_k       (av[(i + 2) % 3]),
         .b_i       (bv[i]),
         .b_j       (bv[(i + 1) % 3]),
         .b_k       (bv[(i + 2) % 3]),
         .eta       (req.payload.eta),
         .fab       (fab_l[i]),
         .fea       (fea_l[i]),
         .sq        (sq_l[i]),
         .cross_q   (cross_l[i]),
         .cross_sat (cross_sat_l[i])
      );
   end

   // Valid chain of the front stages
   logic [7:1] v_ff, v_in;
   logic       v8_ff, v9_ff;

   always_comb begin
      v_in = {v_ff[6:1], req.valid};
   end

   // Stage 1: request context and eta squared
   ctx_type  c1_ff, c1_in;
   prod_type ee_ff, ee_in;

   always_comb begin
      c1_in     = '0;
      c1_in.op  = req.payload.op;
      for (int i = 0; i < 3; i++) begin
         c1_in.a[i] = av[i];
         c1_in.b[i] = bv[i];
      end
      c1_in.eta = req.payload.eta;
      ee_in     = mul32(req.payload.eta, req.payload.eta);
   end

   // Stage 2
   ctx_type c2_ff;
   q_type   e2_ff, e2_in;
   logic    e2sat_ff, e2sat_in;

   always_comb begin
      e2_in    = clamp_q(sx64(ee_ff >>> FRAC_BITS));
      e2sat_in = clamp_hit(sx64(ee_ff >>> FRAC_BITS));
   end

   // Stage 3: merge the lanes
   ctx_type     c3_ff, c3_in;
   q_type       d_ff, d_in, e2_3_ff;
   logic [63:0] sumsq_ff, sumsq_in;

   always_comb begin
      wide_type dsum;
      logic     dsat;
      dsum     = sx64(fab_l[0]) + sx64(fab_l[1]) + sx64(fab_l[2]);
      d_in     = clamp_q(dsum);
      dsat     = clamp_hit(dsum);
      sumsq_in = sq_l[0] + sq_l[1] + sq_l[2];
      c3_in    = c2_ff;
      for (int i = 0; i < 3; i++) begin
         c3_in.fea[i] = fea_l[i];
      end
      unique case (c2_ff.op)
         OP_DOT: begin
            c3_in.scalar = d_in;
            c3_in.sat    = dsat;
         end
         OP_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               c3_in.r[i] = cross_l[i];
            end
            c3_in.sat = cross_sat_l[0] | cross_sat_l[1] | cross_sat_l[2];
         end
         OP_REFLECT: begin
            c3_in.sat = dsat;
         end
         OP_REFRACT: begin
            c3_in.sat = dsat | e2sat_ff;
         end
         default: begin
            c3_in.sat = 1'b0;
         end
      endcase
   end

   // Stage 4: products with the dot result
   ctx_type     c4_ff;
   prod_type    dd_ff, ed_ff, dd_in, ed_in;
   prod_type    db_ff[3], db_in[3];
   q_type       e2_4_ff;
   logic [63:0] sumsq_4_ff;

   always_comb begin
      dd_in = mul32(d_ff, d_ff);
      ed_in = mul32(c3_ff.eta, d_ff);
      for (int i = 0; i < 3; i++) begin
         db_in[i] = mul32(d_ff, c3_ff.b[i]);
      end
   end

   // Stage 5: reflect result, d squared, one minus d squared
   ctx_type     c5_ff, c5_in;
   wide_type    omd_ff, omd_in;
   q_type       e2_5_ff;
   logic [63:0] sumsq_5_ff;

   always_comb begin
      wide_type d2w, t;
      q_type    d2;
      d2w          = sx64(dd_ff >>> FRAC_BITS);
      d2           = clamp_q(d2w);
      omd_in       = ONE - sx32(d2);
      c5_in        = c4_ff;
      c5_in.fed    = ed_ff >>> FRAC_BITS;
      if (c4_ff.op == OP_REFRACT) begin
         c5_in.sat = c4_ff.sat | clamp_hit(d2w);
      end
      // Doubling folds into a shift of one bit less.
      for (int i = 0; i < 3; i++) begin
         t = sx32(c4_ff.a[i]) - sx64(db_ff[i] >>> (FRAC_BITS - 1));
         if (c4_ff.op == OP_REFLECT) begin
            c5_in.r[i] = clamp_q(t);
            c5_in.sat  = c5_in.sat | clamp_hit(t);
         end
      end
   end

   // Stage 6: eta squared times one minus d squared
   ctx_type     c6_ff;
   wide_type    mp_ff, mp_in;
   logic [63:0] sumsq_6_ff;

   always_comb begin
      mp_in = sx32(e2_5_ff) * omd_ff;
   end

   // Stage 7: k and the square-root operand
   ctx_type     c7_ff, c7_in;
   logic [63:0] rad_ff, rad_in;

   always_comb begin
      wide_type mw, k;
      q_type    m;
      mw     = mp_ff >>> FRAC_BITS;
      m      = clamp_q(mw);
      k      = ONE - sx32(m);
      c7_in  = c6_ff;
      rad_in = sumsq_6_ff;
      if (c6_ff.op == OP_REFRACT) begin
         c7_in.sat = c6_ff.sat | clamp_hit(mw);
         c7_in.tir = k < 0;
         rad_in    = (k < 0) ? '0 : (k[63:0] << FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff      <= c1_in;
         ee_ff      <= ee_in;
         c2_ff      <= c1_ff;
         e2_ff      <= e2_in;
         e2sat_ff   <= e2sat_in;
         c3_ff      <= c3_in;
         d_ff       <= d_in;
         e2_3_ff    <= e2_ff;
         sumsq_ff   <= sumsq_in;
         c4_ff      <= c3_ff;
         dd_ff      <= dd_in;
         ed_ff      <= ed_in;
         db_ff      <= db_in;
         e2_4_ff    <= e2_3_ff;
         sumsq_4_ff <= sumsq_ff;
         c5_ff      <= c5_in;
         omd_ff     <= omd_in;
         e2_5_ff    <= e2_4_ff;
         sumsq_5_ff <= sumsq_4_ff;
         c6_ff      <= c5_ff;
         mp_ff      <= mp_in;
         sumsq_6_ff <= sumsq_5_ff;
         c7_ff      <= c7_in;
         rad_ff     <= rad_in;
      end
   end

   // Shared square root
   logic        vs;
   logic [31:0] root;
   ctx_type     cs;

   vec3g_isqrt #(.side_type(ctx_type)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v_ff[7]),
      .radicand  (rad_ff),
      .side_in   (c7_ff),
      .out_valid (vs),
      .root      (root),
      .side_out  (cs)
   );

   // Stage after the root: length, zero check, refract coefficient
   ctx_type     c8_ff, c8_in;
   logic [31:0] l_ff, l_in;
   logic [63:0] num_ff[3], num_in[3];

   always_comb begin
      wide_type rw, cw, mag;
      rw    = wide_type'({1'b0, root});
      cw    = sx64(cs.fed) + rw;
      c8_in = cs;
      l_in  = root;
      unique case (cs.op)
         OP_LENGTH: begin
            c8_in.scalar = clamp_q(rw);
            c8_in.sat    = clamp_hit(rw);
         end
         OP_NORMALIZE: begin
            c8_in.dz = (root == '0);
         end
         OP_REFRACT: begin
            c8_in.c = clamp_q(cw);
            if (!cs.tir) begin
               c8_in.sat = cs.sat | clamp_hit(cw);
            end
         end
         default: begin
            c8_in.dz = 1'b0;
         end
      endcase
      for (int i = 0; i < 3; i++) begin
         mag       = cs.a[i][31] ? (wide_type'(0) - sx32(cs.a[i])) : sx32(cs.a[i]);
         num_in[i] = mag[63:0] << FRAC_BITS;
      end
   end

   // Stage 9: refract products c times b
   ctx_type     c9_ff, c9_in;
   logic [31:0] l2_ff;
   logic [63:0] num2_ff[3];

   always_comb begin
      c9_in = c8_ff;
      for (int i = 0; i < 3; i++) begin
         c9_in.cb[i] = mul32(c8_ff.c, c8_ff.b[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (en) begin
         v8_ff <= vs;
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c8_ff   <= c8_in;
         l_ff    <= l_in;
         num_ff  <= num_in;
         c9_ff   <= c9_in;
         l2_ff   <= l_ff;
         num2_ff <= num_ff;
      end
   end

   // Normalize divider
   logic        vd;
   logic [31:0] quot[3];
   ctx_type     cd;

   vec3g_div #(.FRAC_BITS(FRAC_BITS), .side_type(ctx_type)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v9_ff),
      .num       (num2_ff),
      .den       (l2_ff),
      .side_in   (c9_ff),
      .out_valid (vd),
      .quot      (quot),
      .side_out  (cd)
   );

   // Final selection into the output register
   always_comb begin
      q_type    rv[3];
      logic     sat;
      wide_type t;
      for (int i = 0; i < 3; i++) begin
         rv[i] = cd.r[i];
      end
      sat    = cd.sat;
      t      = '0;
      rsp_in = '0;
      unique case (cd.op) inside
         OP_DOT, OP_LENGTH: begin
            rsp_in.res_scalar = cd.scalar;
         end
         OP_NORMALIZE: begin
            rsp_in.div_by_zero = cd.dz;
            for (int i = 0; i < 3; i++) begin
               if (cd.dz) begin
                  rv[i] = '0;
               end else begin
                  rv[i] = cd.a[i][31] ? q_type'(32'd0 - quot[i]) : q_type'(quot[i]);
               end
            end
         end
         OP_REFRACT: begin
            rsp_in.total_reflection = cd.tir;
            for (int i = 0; i < 3; i++) begin
               t = sx64(cd.fea[i]) - sx64($signed(cd.cb[i]) >>> FRAC_BITS);
               if (cd.tir) begin
                  rv[i] = '0;
               end else begin
                  rv[i] = clamp_q(t);
                  sat   = sat | clamp_hit(t);
               end
            end
         end
         default: begin
            sat = cd.sat;
         end
      endcase
      if (cd.op == OP_CROSS || cd.op == OP_REFLECT || cd.op == OP_NORMALIZE
          || cd.op == OP_REFRACT) begin
         rsp_in.res_x = rv[0];
         rsp_in.res_y = rv[1];
         rsp_in.res_z = rv[2];
      end
      if (cd.op <= OP_REFRACT) begin
         rsp_in.saturated = sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vd;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
